FILE: rtl/pwhc_pkg.sv
// Shared constants, register codes and types for the phi wedge halo classifier.
// No dependencies; every other file imports this package.
`default_nettype none

package pwhc_pkg;

	// phi map geometry
	localparam int unsigned PHI_BINS   = 512;
	localparam int unsigned PHI_W      = 9;
	localparam int unsigned ROW_BITS   = 8;
	localparam int unsigned ROW_SEL_W  = 3;
	localparam int unsigned ROWS       = (PHI_BINS + ROW_BITS - 1) / ROW_BITS;
	localparam int unsigned ROW_W      = $clog2(ROWS);
	localparam int unsigned PHI_CMP_W  = 11;

	// field widths
	localparam int unsigned ENERGY_W   = 16;
	localparam int unsigned COUNT_W    = 12;
	localparam int unsigned CONF_W     = 16;
	localparam int unsigned THR_Q_W    = 15;
	localparam int unsigned MAG_W      = 17;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_LOOSE_ENERGY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOSE_COUNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOSE_CONF   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIGHT_ENERGY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIGHT_COUNT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TIGHT_CONF   = 3'd5;

	typedef struct packed {
		logic [ENERGY_W-1:0] energy_min;
		logic [COUNT_W-1:0]  count_min;
		logic [THR_Q_W-1:0]  conf_min;
	} cut_thr_t;

	// request from the classifier stage to the suspect map
	typedef struct packed {
		logic             en;      // stage 1 word retires this cycle
		logic             passed;  // loose or tight
		logic             last;    // event end: clear map after this word
		logic [PHI_W-1:0] phi;
	} map_req_t;

endpackage

`default_nettype wire

FILE: rtl/pwhc_if.sv
// Handshake interfaces of the phi wedge halo classifier: wedge, result, config.
// Depends on pwhc_pkg.
`default_nettype none

interface pwhc_wedge_if import pwhc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [ENERGY_W-1:0]        wedge_energy;
	logic [COUNT_W-1:0]         constituent_count;
	logic signed [CONF_W-1:0]   direction_confidence;
	logic [PHI_W-1:0]           phi_index;
	logic                       event_end;

	modport source (output valid, wedge_energy, constituent_count, direction_confidence,
		phi_index, event_end, input ready);
	modport sink (input valid, wedge_energy, constituent_count, direction_confidence,
		phi_index, event_end, output ready);
endinterface

interface pwhc_result_if import pwhc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             passes_loose;
	logic             passes_tight;
	logic             new_suspect;
	logic [PHI_W-1:0] suspect_phi;
	logic             event_loose;
	logic             event_tight;
	logic             event_done;

	modport source (output valid, passes_loose, passes_tight, new_suspect, suspect_phi,
		event_loose, event_tight, event_done, input ready);
	modport sink (input valid, passes_loose, passes_tight, new_suspect, suspect_phi,
		event_loose, event_tight, event_done, output ready);
endinterface

interface pwhc_cfg_if import pwhc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/pwhc_cut.sv
// One cut set: strict energy, count and confidence magnitude compares.
// Depends on pwhc_pkg.
`default_nettype none

module pwhc_cut import pwhc_pkg::*; (
	input  logic [ENERGY_W-1:0] energy,
	input  logic [COUNT_W-1:0]  count,
	input  logic [MAG_W-1:0]    mag,
	input  cut_thr_t            thr,
	output logic                pass
);

	assign pass = (energy > thr.energy_min)
		&& (count > thr.count_min)
		&& (mag > MAG_W'(thr.conf_min));

endmodule

`default_nettype wire

FILE: rtl/pwhc_map.sv
// Suspect phi bitmap: row memory with per-row valid flops and last-write bypass.
// Depends on pwhc_pkg.
`default_nettype none

module pwhc_map import pwhc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [PHI_W-1:0] rd_phi,
	input  map_req_t         req,
	output logic             fresh
);

	logic [ROW_BITS-1:0] mem [ROWS];
	logic [ROW_BITS-1:0] rd_q;
	logic [ROWS-1:0]     row_vld_q;
	logic                lw_vld_q;
	logic [ROW_W-1:0]    lw_row_q;
	logic [ROW_BITS-1:0] lw_data_q;

	logic [ROW_W-1:0]     rd_row;
	logic [ROW_W-1:0]     row;
	logic [ROW_SEL_W-1:0] sel;
	logic                 in_map;
	logic [ROW_BITS-1:0]  base;
	logic [ROW_BITS-1:0]  new_row;
	logic                 wr_en;

	assign rd_row = ROW_W'(rd_phi >> ROW_SEL_W);
	assign row    = ROW_W'(req.phi >> ROW_SEL_W);
	assign sel    = req.phi[ROW_SEL_W-1:0];
	assign in_map = PHI_CMP_W'(req.phi) < PHI_CMP_W'(PHI_BINS);

	// invalid row reads as clear; the newest write to the row wins over the
	// memory word, which may have been read in the same edge that wrote it
	always_comb begin
		if (!(in_map && row_vld_q[row])) begin
			base = '0;
		end else if (lw_vld_q && (lw_row_q == row)) begin
			base = lw_data_q;
		end else begin
			base = rd_q;
		end
	end

	assign fresh   = req.passed && in_map && !base[sel];
	assign new_row = base | (ROW_BITS'(1) << sel);
	assign wr_en   = req.en && fresh && !req.last;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_row];
		end
		if (wr_en) begin
			mem[row] <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			lw_vld_q  <= 1'b0;
		end else if (req.en && req.last) begin
			row_vld_q <= '0;
			lw_vld_q  <= 1'b0;
		end else if (wr_en) begin
			row_vld_q[row] <= 1'b1;
			lw_vld_q       <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lw_row_q  <= row;
			lw_data_q <= new_row;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/phi_wedge_halo_classifier.sv
// Top level of the phi wedge halo classifier: config registers, stage 1, result register.
// Depends on pwhc_pkg, pwhc_if, pwhc_cut and pwhc_map.
//
//   channel  dir  handshake      word
//   cfg      in   valid/ready    index, data (register write, ready always high)
//   wedge    in   valid/ready    energy, count, confidence, phi, event end
//   result   out  valid/ready    pass flags, new suspect, phi, event flags, done
//
// One word in per cycle sustained while result.ready stays high; each wedge passes
// the stage 1 register (with the suspect row read), then the result register.
// Reset clears thresholds, event flags and the bitmap row valid flags at once.
// A stalled result holds stage 1; wedge.ready drops only while both are full.
// Config is to be written while no wedge is in flight.
`default_nettype none

module phi_wedge_halo_classifier import pwhc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	pwhc_cfg_if.sink      cfg,
	pwhc_wedge_if.sink    wedge,
	pwhc_result_if.source result
);

	// thresholds
	cut_thr_t loose_thr_q;
	cut_thr_t tight_thr_q;

	// stage 1
	logic                     s1_v_q;
	logic [ENERGY_W-1:0]      energy_s1;
	logic [COUNT_W-1:0]       count_s1;
	logic signed [CONF_W-1:0] conf_s1;
	logic [PHI_W-1:0]         phi_s1;
	logic                     last_s1;

	// event flags
	logic any_loose_q;
	logic any_tight_q;

	// result register
	logic             res_v_q;
	logic             loose_q;
	logic             tight_q;
	logic             fresh_q;
	logic [PHI_W-1:0] phi_q;
	logic             ev_loose_q;
	logic             ev_tight_q;
	logic             done_q;

	logic             in_fire;
	logic             s1_adv;
	logic [MAG_W-1:0] mag;
	logic             loose;
	logic             tight;
	logic             fresh;
	map_req_t         map_req;

	assign cfg.ready = 1'b1;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loose_thr_q <= '0;
			tight_thr_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LOOSE_ENERGY: loose_thr_q.energy_min <= cfg.data;
				REG_LOOSE_COUNT:  loose_thr_q.count_min  <= cfg.data[COUNT_W-1:0];
				REG_LOOSE_CONF:   loose_thr_q.conf_min   <= cfg.data[THR_Q_W-1:0];
				REG_TIGHT_ENERGY: tight_thr_q.energy_min <= cfg.data;
				REG_TIGHT_COUNT:  tight_thr_q.count_min  <= cfg.data[COUNT_W-1:0];
				REG_TIGHT_CONF:   tight_thr_q.conf_min   <= cfg.data[THR_Q_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 moves on when the result register is free or being drained
	assign s1_adv      = s1_v_q && (!res_v_q || result.ready);
	assign wedge.ready = !s1_v_q || s1_adv;
	assign in_fire     = wedge.valid && wedge.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (in_fire) begin
			s1_v_q <= 1'b1;
		end else if (s1_adv) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			energy_s1 <= wedge.wedge_energy;
			count_s1  <= wedge.constituent_count;
			conf_s1   <= wedge.direction_confidence;
			phi_s1    <= wedge.phi_index;
			last_s1   <= wedge.event_end;
		end
	end

	// |conf| at 17 bits so the most negative code gives 32768
	assign mag = conf_s1[CONF_W-1] ? (MAG_W'(1 << CONF_W) - MAG_W'($unsigned(conf_s1)))
		: MAG_W'($unsigned(conf_s1));

	pwhc_cut u_loose (
		.energy (energy_s1),
		.count  (count_s1),
		.mag    (mag),
		.thr    (loose_thr_q),
		.pass   (loose)
	);

	pwhc_cut u_tight (
		.energy (energy_s1),
		.count  (count_s1),
		.mag    (mag),
		.thr    (tight_thr_q),
		.pass   (tight)
	);

	// row read rides the accept edge; mark/clear lands when stage 1 retires
	assign map_req.en     = s1_adv;
	assign map_req.passed = loose || tight;
	assign map_req.last   = last_s1;
	assign map_req.phi    = phi_s1;

	pwhc_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_fire),
		.rd_phi (wedge.phi_index),
		.req    (map_req),
		.fresh  (fresh)
	);

	// event flags include the wedge itself, then clear after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_loose_q <= 1'b0;
			any_tight_q <= 1'b0;
		end else if (s1_adv) begin
			any_loose_q <= !last_s1 && (any_loose_q || loose);
			any_tight_q <= !last_s1 && (any_tight_q || tight);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (s1_adv) begin
			res_v_q <= 1'b1;
		end else if (result.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			loose_q    <= loose;
			tight_q    <= tight;
			fresh_q    <= fresh;
			phi_q      <= phi_s1;
			ev_loose_q <= any_loose_q || loose;
			ev_tight_q <= any_tight_q || tight;
			done_q     <= last_s1;
		end
	end

	assign result.valid        = res_v_q;
	assign result.passes_loose = loose_q;
	assign result.passes_tight = tight_q;
	assign result.new_suspect  = fresh_q;
	assign result.suspect_phi  = phi_q;
	assign result.event_loose  = ev_loose_q;
	assign result.event_tight  = ev_tight_q;
	assign result.event_done   = done_q;

	a_fresh_needs_pass: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && fresh_q |-> loose_q || tight_q)
		else $error("new suspect without a passing cut");

	a_event_covers_wedge: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q |-> (!loose_q || ev_loose_q) && (!tight_q || ev_tight_q))
		else $error("event flag misses this wedge");

	a_flags_clear_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && last_s1 |=> !any_loose_q && !any_tight_q)
		else $error("event flags not cleared after event end");

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && !s1_adv |=> s1_v_q && $stable(phi_s1) && $stable(last_s1))
		else $error("stage 1 word lost during stall");

endmodule

`default_nettype wire
